// File: hw/rtl/bale_pkg.sv
package bale_pkg;

   localparam int unsigned WORD_W = 32;

   // request operation codes
   typedef enum logic [2:0] {
      OP_APPEND       = 3'd0,
      OP_PREPEND      = 3'd1,
      OP_INSERT       = 3'd2,
      OP_REMOVE_LAST  = 3'd3,
      OP_REMOVE_FIRST = 3'd4,
      OP_READ         = 3'd5
   } op_type;

   // response status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   // store update selected for the current request
   typedef enum logic [1:0] {
      WR_NONE         = 2'd0,
      WR_INSERT       = 2'd1,
      WR_REMOVE_FIRST = 2'd2,
      WR_REMOVE_LAST  = 2'd3
   } wr_kind_type;

   // slot that receives an inserted word
   typedef enum logic [1:0] {
      INS_END   = 2'd0,
      INS_FRONT = 2'd1,
      INS_POS   = 2'd2
   } ins_sel_type;

   // slot read for the response word
   typedef enum logic [1:0] {
      RD_LAST  = 2'd0,
      RD_FIRST = 2'd1,
      RD_POS   = 2'd2
   } rd_sel_type;

   // controller to datapath
   typedef struct packed {
      logic        load;
      wr_kind_type wr_kind;
      ins_sel_type ins_sel;
      rd_sel_type  rd_sel;
      logic        keep_data;
      status_type  status;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic full;
      logic empty;
      logic pos_le_count;
      logic pos_lt_count;
   } flags_type;

endpackage

// File: hw/rtl/bale_ctrl.sv
module bale_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_op,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  bale_pkg::flags_type flags,
   output bale_pkg::cmd_type   cmd
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_HOLD = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   // take a new request unless a response is held and stalled
   assign req_stall = (state_ff == S_HOLD) && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = (state_ff == S_HOLD);

   // advance the response slot
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_HOLD;
         end
         S_HOLD: begin
            if (accept) state_in = S_HOLD;
            else if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   // decode the request into a datapath command
   always_comb begin
      cmd           = '0;
      cmd.load      = accept;
      cmd.wr_kind   = bale_pkg::WR_NONE;
      cmd.ins_sel   = bale_pkg::INS_END;
      cmd.rd_sel    = bale_pkg::RD_POS;
      cmd.keep_data = 1'b0;
      cmd.status    = bale_pkg::ST_OK;
      unique case (bale_pkg::op_type'(req_op))
         bale_pkg::OP_APPEND, bale_pkg::OP_PREPEND, bale_pkg::OP_INSERT: begin
            if (req_op == bale_pkg::OP_PREPEND) cmd.ins_sel = bale_pkg::INS_FRONT;
            else if (req_op == bale_pkg::OP_INSERT) cmd.ins_sel = bale_pkg::INS_POS;
            if (flags.full) begin
               cmd.status = bale_pkg::ST_FULL;
            end else if (req_op == bale_pkg::OP_INSERT && !flags.pos_le_count) begin
               cmd.status = bale_pkg::ST_RANGE;
            end else begin
               cmd.wr_kind = bale_pkg::WR_INSERT;
            end
         end
         bale_pkg::OP_REMOVE_LAST: begin
            cmd.rd_sel = bale_pkg::RD_LAST;
            if (flags.empty) begin
               cmd.status = bale_pkg::ST_EMPTY;
            end else begin
               cmd.wr_kind   = bale_pkg::WR_REMOVE_LAST;
               cmd.keep_data = 1'b1;
            end
         end
         bale_pkg::OP_REMOVE_FIRST: begin
            cmd.rd_sel = bale_pkg::RD_FIRST;
            if (flags.empty) begin
               cmd.status = bale_pkg::ST_EMPTY;
            end else begin
               cmd.wr_kind   = bale_pkg::WR_REMOVE_FIRST;
               cmd.keep_data = 1'b1;
            end
         end
         bale_pkg::OP_READ: begin
            if (flags.empty) cmd.status = bale_pkg::ST_EMPTY;
            else if (!flags.pos_lt_count) cmd.status = bale_pkg::ST_RANGE;
            else cmd.keep_data = 1'b1;
         end
         default: begin
            // unused codes change nothing and answer ok
            cmd.status = bale_pkg::ST_OK;
         end
      endcase
      // drop store updates for requests not taken
      if (!accept) cmd.wr_kind = bale_pkg::WR_NONE;
   end

endmodule

// File: hw/rtl/bale_dp.sv
module bale_dp #(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned CW    = 5
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic signed [bale_pkg::WORD_W-1:0] req_item_value,
   input  logic [CW-1:0]                  req_position,
   input  bale_pkg::cmd_type              cmd,
   output bale_pkg::flags_type            flags,
   output logic [1:0]                     rsp_status,
   output logic [CW-1:0]                  rsp_fill_count,
   output logic signed [bale_pkg::WORD_W-1:0] rsp_data_out
);

   localparam int unsigned IW = $clog2(DEPTH);
   localparam int unsigned WW = bale_pkg::WORD_W;

   logic [WW-1:0] entries_ff [DEPTH];
   logic [WW-1:0] entries_in [DEPTH];
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic [CW-1:0] ins_pos;
   logic [CW-1:0] last_pos;
   logic [IW-1:0] rd_addr;
   logic [WW-1:0] rd_data;

   logic [1:0]    status_ff;
   logic [CW-1:0] fill_ff;
   logic [WW-1:0] data_ff;

   // report list state to the controller
   assign flags.full         = (count_ff == CW'(DEPTH));
   assign flags.empty        = (count_ff == '0);
   assign flags.pos_le_count = (req_position <= count_ff);
   assign flags.pos_lt_count = (req_position < count_ff);

   // pick the insert slot
   always_comb begin
      unique case (cmd.ins_sel)
         bale_pkg::INS_END:   ins_pos = count_ff;
         bale_pkg::INS_FRONT: ins_pos = '0;
         bale_pkg::INS_POS:   ins_pos = req_position;
         default:             ins_pos = count_ff;
      endcase
   end

   // per-slot next value: keep, take the lower neighbor, take the new word
   // or take the upper neighbor
   for (genvar i = 0; i < DEPTH; i++) begin : g_slot
      always_comb begin
         entries_in[i] = entries_ff[i];
         unique case (cmd.wr_kind)
            bale_pkg::WR_INSERT: begin
               if (CW'(i) == ins_pos) begin
                  entries_in[i] = req_item_value;
               end else if (CW'(i) > ins_pos) begin
                  if (i > 0) entries_in[i] = entries_ff[(i > 0) ? i - 1 : 0];
               end
            end
            bale_pkg::WR_REMOVE_FIRST: begin
               if (i < DEPTH - 1) entries_in[i] = entries_ff[(i < DEPTH - 1) ? i + 1 : i];
            end
            default: entries_in[i] = entries_ff[i];
         endcase
      end

      always_ff @(posedge clock) begin
         entries_ff[i] <= entries_in[i];
      end
   end

   // update the fill count
   always_comb begin
      unique case (cmd.wr_kind)
         bale_pkg::WR_INSERT:       count_in = count_ff + CW'(1);
         bale_pkg::WR_REMOVE_FIRST,
         bale_pkg::WR_REMOVE_LAST:  count_in = count_ff - CW'(1);
         default:                   count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else count_ff <= count_in;
   end

   // read the word for pops and reads
   assign last_pos = count_ff - CW'(1);

   always_comb begin
      unique case (cmd.rd_sel)
         bale_pkg::RD_LAST:  rd_addr = last_pos[IW-1:0];
         bale_pkg::RD_FIRST: rd_addr = '0;
         bale_pkg::RD_POS:   rd_addr = req_position[IW-1:0];
         default:            rd_addr = '0;
      endcase
   end

   assign rd_data = entries_ff[rd_addr];

   // hold the response until taken
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         status_ff <= cmd.status;
         fill_ff   <= count_in;
         data_ff   <= cmd.keep_data ? rd_data : '0;
      end
   end

   assign rsp_status     = status_ff;
   assign rsp_fill_count = fill_ff;
   assign rsp_data_out   = data_ff;

endmodule

// File: hw/rtl/bounded_array_list_engine_top.sv
// The response to an accepted request is registered and valid in the cycle after it is taken.
// One request per cycle while the held response is not stalled; inserts and removals shift the slots of the
// register array in parallel, so the update is made in the accept cycle.
// A new request is taken while the held response is not stalled.
// Reset (synchronous, active high) empties the list and drops any held response;
// stored words are not cleared.
module bounded_array_list_engine_top #(
   parameter int unsigned DEPTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [2:0]                  req_op,
   input  logic signed [31:0]          req_item_value,
   input  logic [$clog2(DEPTH+1)-1:0]  req_position,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_status,
   output logic [$clog2(DEPTH+1)-1:0]  rsp_fill_count,
   output logic signed [31:0]          rsp_data_out
);

   localparam int unsigned CW = $clog2(DEPTH + 1);

   bale_pkg::cmd_type   cmd;
   bale_pkg::flags_type flags;

   bale_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .flags     (flags),
      .cmd       (cmd)
   );

   bale_dp #(
      .DEPTH (DEPTH),
      .CW    (CW)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_item_value (req_item_value),
      .req_position   (req_position),
      .cmd            (cmd),
      .flags          (flags),
      .rsp_status     (rsp_status),
      .rsp_fill_count (rsp_fill_count),
      .rsp_data_out   (rsp_data_out)
   );

endmodule

// File: sim/bounded_array_list_engine_top_tb.sv
module bounded_array_list_engine_top_tb;

   localparam int LIST_DEPTH = 16;
   localparam int POS_W = $clog2(LIST_DEPTH + 1);
   localparam int REQUEST_TOTAL = 1600;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 60;

   // op codes with no operation behind them
   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   typedef struct {
      logic [2:0]         op;
      logic signed [31:0] value;
      logic [POS_W-1:0]   pos;
   } list_request_type;

   typedef struct {
      bale_pkg::status_type status;
      logic [POS_W-1:0]     fill;
      logic signed [31:0]   word;
   } list_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [2:0]               req_op = OP_SPARE_LO;
   logic signed [31:0]       req_item_value = '0;
   logic [POS_W-1:0]         req_position = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [1:0]               rsp_status;
   logic [POS_W-1:0]         rsp_fill_count;
   logic signed [31:0]       rsp_data_out;

   // predictor state: the list contents and its fill
   logic signed [31:0]       list_words [LIST_DEPTH];
   int                       list_fill = 0;

   list_request_type         pending_requests [$];
   list_result_type          list_results_due [$];
   list_request_type         next_request;

   int                       gen_fill = 0;
   int                       gen_items = 0;
   int                       send_idle_pct = 35;
   int                       recv_idle_pct = 35;
   int                       requests_sent = 0;
   int                       responses_checked = 0;
   int                       status_seen [4] = '{0, 0, 0, 0};
   int                       hold_left = 0;
   int                       error_count = 0;
   int                       cycle_count = 0;

   bounded_array_list_engine_top #(
      .DEPTH(LIST_DEPTH)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_item_value(req_item_value),
      .req_position  (req_position),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_fill_count(rsp_fill_count),
      .rsp_data_out  (rsp_data_out)
   );

   always #6 clock = ~clock;

   // apply one request to the predicted list and return the expected response
   function automatic list_result_type apply_list_op(logic [2:0] op, logic signed [31:0] value,
                                                     logic [POS_W-1:0] pos);
      list_result_type res;
      int slot;
      res.status = bale_pkg::ST_OK;
      res.word = '0;
      case (op)
         bale_pkg::OP_APPEND, bale_pkg::OP_PREPEND, bale_pkg::OP_INSERT: begin
            if (list_fill >= LIST_DEPTH) begin
               res.status = bale_pkg::ST_FULL;
            end else begin
               if (op == bale_pkg::OP_APPEND) slot = list_fill;
               else if (op == bale_pkg::OP_PREPEND) slot = 0;
               else slot = pos;
               if (slot > list_fill) begin
                  res.status = bale_pkg::ST_RANGE;
               end else begin
                  // open a gap at the slot
                  for (int i = list_fill; i > slot; i--) list_words[i] = list_words[i-1];
                  list_words[slot] = value;
                  list_fill++;
               end
            end
         end
         bale_pkg::OP_REMOVE_LAST: begin
            if (list_fill == 0) begin
               res.status = bale_pkg::ST_EMPTY;
            end else begin
               res.word = list_words[list_fill-1];
               list_fill--;
            end
         end
         bale_pkg::OP_REMOVE_FIRST: begin
            if (list_fill == 0) begin
               res.status = bale_pkg::ST_EMPTY;
            end else begin
               res.word = list_words[0];
               // close the gap at the front
               for (int i = 0; i + 1 < list_fill; i++) list_words[i] = list_words[i+1];
               list_fill--;
            end
         end
         bale_pkg::OP_READ: begin
            if (list_fill == 0) res.status = bale_pkg::ST_EMPTY;
            else if (pos >= list_fill) res.status = bale_pkg::ST_RANGE;
            else res.word = list_words[pos];
         end
         default: ;
      endcase
      res.fill = list_fill[POS_W-1:0];
      return res;
   endfunction

   // queue one request and track the fill it leads to
   function automatic void add_request(logic [2:0] op, logic signed [31:0] value,
                                       logic [POS_W-1:0] pos);
      list_request_type r;
      r.op = op;
      r.value = value;
      r.pos = pos;
      pending_requests.push_back(r);
      gen_items++;
      if (op == bale_pkg::OP_APPEND || op == bale_pkg::OP_PREPEND ||
          op == bale_pkg::OP_INSERT) begin
         if (gen_fill < LIST_DEPTH && (op != bale_pkg::OP_INSERT || pos <= gen_fill))
            gen_fill++;
      end else if (op == bale_pkg::OP_REMOVE_LAST || op == bale_pkg::OP_REMOVE_FIRST) begin
         if (gen_fill > 0) gen_fill--;
      end
   endfunction

   // mostly random words, now and then an extreme one
   function automatic logic signed [31:0] pick_word();
      case ($urandom_range(11))
         0: return 32'sh7FFFFFFF;
         1: return 32'sh80000000;
         2: return 32'sh00000000;
         3: return 32'shFFFFFFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
      $display("mismatch in %s of response %0d: expected %0h, got %0h",
               what, responses_checked, want, got);
      error_count++;
   endtask

   // drive requests, predicting each one as it is taken
   always @(posedge clock) begin
      list_request_type head;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            list_results_due.push_back(apply_list_op(req_op, req_item_value, req_position));
            requests_sent <= requests_sent + 1;
         end
         if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            head = pending_requests[0];
            pending_requests.delete(0);
            req_op <= head.op;
            req_item_value <= head.value;
            req_position <= head.pos;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // count down the long receive hold
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (rsp_valid && !rsp_stall &&
                   (responses_checked == 250 || responses_checked == 1100)) begin
         // hold off long enough for the engine to back up its input
         hold_left <= HOLD_CYCLES;
      end
   end

   // check responses and drive the stall
   always @(posedge clock) begin
      list_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (list_results_due.size() == 0) begin
               $display("response %0d arrived with no request outstanding", responses_checked);
               error_count++;
            end else begin
               want = list_results_due[0];
               list_results_due.delete(0);
               if (rsp_status !== want.status)
                  flag_mismatch("status", 32'(want.status), 32'(rsp_status));
               if (rsp_fill_count !== want.fill)
                  flag_mismatch("fill count", 32'(want.fill), 32'(rsp_fill_count));
               if (rsp_data_out !== want.word)
                  flag_mismatch("data", want.word, rsp_data_out);
            end
            status_seen[rsp_status]++;
            responses_checked <= responses_checked + 1;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("bounded_array_list_engine_top_tb: errors");
         $finish;
      end
   end

   initial begin
      int pick;
      // corner cases from an empty list
      add_request(bale_pkg::OP_REMOVE_LAST, 32'sd0, 0);
      add_request(bale_pkg::OP_REMOVE_FIRST, 32'sd0, 0);
      add_request(bale_pkg::OP_READ, 32'sd0, 0);
      add_request(OP_SPARE_LO, 32'sh7FFFFFFF, 5);
      add_request(OP_SPARE_HI, 32'sh80000000, 16);
      add_request(bale_pkg::OP_APPEND, 32'sh7FFFFFFF, 16);
      add_request(bale_pkg::OP_PREPEND, 32'sh80000000, 0);
      add_request(bale_pkg::OP_INSERT, 32'sd0, 1);
      add_request(bale_pkg::OP_INSERT, 32'shFFFFFFFF, 3);
      add_request(bale_pkg::OP_INSERT, 32'sh12345678, 5);
      add_request(bale_pkg::OP_READ, 32'sd0, 4);
      add_request(bale_pkg::OP_READ, 32'sd0, 16);
      add_request(bale_pkg::OP_READ, 32'sd0, 0);
      add_request(bale_pkg::OP_READ, 32'sd0, 3);
      add_request(OP_SPARE_HI, 32'sd1, 2);
      add_request(bale_pkg::OP_REMOVE_FIRST, 32'sd0, 0);
      add_request(bale_pkg::OP_REMOVE_LAST, 32'sd0, 0);
      add_request(bale_pkg::OP_INSERT, 32'sh5A5A5A5A, 16);

      // random part: fill bursts, drain bursts, mixed traffic and noise
      while (gen_items < REQUEST_TOTAL) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            while (gen_fill < LIST_DEPTH)
               add_request(3'($urandom_range(bale_pkg::OP_APPEND, bale_pkg::OP_INSERT)),
                           pick_word(), POS_W'($urandom_range(gen_fill)));
            repeat (1 + $urandom_range(2))
               add_request(3'($urandom_range(bale_pkg::OP_APPEND, bale_pkg::OP_INSERT)),
                           pick_word(), POS_W'($urandom_range(LIST_DEPTH)));
            add_request(bale_pkg::OP_READ, 32'sd0, POS_W'($urandom_range(LIST_DEPTH - 1)));
         end else if (pick < 18) begin
            while (gen_fill > 0)
               add_request(3'($urandom_range(bale_pkg::OP_REMOVE_LAST,
                                             bale_pkg::OP_REMOVE_FIRST)),
                           pick_word(), POS_W'($urandom_range(LIST_DEPTH)));
            repeat (1 + $urandom_range(1))
               add_request(3'($urandom_range(bale_pkg::OP_REMOVE_LAST, bale_pkg::OP_READ)),
                           pick_word(), POS_W'($urandom_range(LIST_DEPTH)));
         end else if (pick < 25) begin
            add_request(3'($urandom_range(bale_pkg::OP_APPEND, OP_SPARE_HI)), pick_word(),
                        POS_W'($urandom_range(LIST_DEPTH)));
         end else begin
            next_request.op = 3'($urandom_range(bale_pkg::OP_APPEND, bale_pkg::OP_READ));
            next_request.pos = POS_W'($urandom_range(LIST_DEPTH));
            if ($urandom_range(9) != 0) begin
               if (next_request.op == bale_pkg::OP_INSERT)
                  next_request.pos = POS_W'($urandom_range(gen_fill));
               else if (next_request.op == bale_pkg::OP_READ && gen_fill > 0)
                  next_request.pos = POS_W'($urandom_range(gen_fill - 1));
            end
            add_request(next_request.op, pick_word(), next_request.pos);
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // stretch with no idling on either side
      while (requests_sent < 600) @(posedge clock);
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
      while (requests_sent < 900) @(posedge clock);
      send_idle_pct <= 35;
      recv_idle_pct <= 35;

      // drain
      while (pending_requests.size() != 0 || req_valid) @(posedge clock);
      while (list_results_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("%0d requests sent, %0d responses checked", requests_sent, responses_checked);
      $display("statuses seen: %0d ok, %0d full, %0d empty, %0d out of range",
               status_seen[bale_pkg::ST_OK], status_seen[bale_pkg::ST_FULL],
               status_seen[bale_pkg::ST_EMPTY], status_seen[bale_pkg::ST_RANGE]);
      if (error_count == 0) begin
         $display("bounded_array_list_engine_top_tb: clean");
      end else begin
         $display("bounded_array_list_engine_top_tb: errors");
      end
      $finish;
   end

endmodule

// File: bounded_array_list_engine_top.f
hw/rtl/bale_pkg.sv
hw/rtl/bale_ctrl.sv
hw/rtl/bale_dp.sv
hw/rtl/bounded_array_list_engine_top.sv
sim/bounded_array_list_engine_top_tb.sv
